[src/lni_pkg.sv]
// Shared constants for the periodic 4D lattice neighbor index block.
// No dependencies.
`timescale 1ns / 1ps
package lni_pkg;

  localparam int IDX_W  = 48;  // site index width
  localparam int CFG_W  = 13;  // side register width
  localparam int NDIM   = 4;
  localparam int DIR_W  = 2;
  localparam int BPS    = 4;   // quotient bits resolved per divider stage
  localparam int DIV_ST = IDX_W / BPS;  // stages per dimension

  typedef enum logic [DIR_W-1:0] {
    REG_SIDE_DIM0 = 2'd0,
    REG_SIDE_DIM1 = 2'd1,
    REG_SIDE_DIM2 = 2'd2,
    REG_SIDE_DIM3 = 2'd3
  } reg_idx_t;

endpackage

[src/lni_if.sv]
// Valid/ready channel interfaces for lattice neighbor index items.
// Depends on lni_pkg.
`timescale 1ns / 1ps
interface lni_in_if import lni_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] site_index;
  logic [DIR_W-1:0] direction;
  logic             kind;

  modport source (output valid, site_index, direction, kind, input ready);
  modport sink   (input valid, site_index, direction, kind, output ready);
endinterface

interface lni_out_if import lni_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] neighbor_index;
  logic             index_error;

  modport source (output valid, neighbor_index, index_error, input ready);
  modport sink   (input valid, neighbor_index, index_error, output ready);
endinterface

[src/lattice_neighbor_index_top.sv]
// Periodic 4D lattice neighbor index: decode, step with wrap, re-encode.
// Depends on lni_pkg and the channel interfaces in lni_if.sv.
//
// Usage:
//   in_ch carries site_index, direction and kind; out_ch returns
//   neighbor_index and index_error, one result per item, in order.
//   cfg_we/cfg_addr/cfg_wdata write the four lattice sides (index 0..3);
//   write them only while no item is in flight.
// Throughput: one item per cycle unless out_ch stalls. Each dimension is a
//   restoring divider of IDX_W/BPS stages resolving BPS quotient bits each;
//   then one step stage and three multiply-add fold stages, the last being
//   the output register.
// Reset: clears all valid bits; sides return to 8.
// Stall: when out_ch.ready is low with a result waiting, the whole pipeline
//   holds and in_ch.ready drops; nothing is lost or repeated.
// An index at or above the volume gives index_error=1 and a zero index.
`timescale 1ns / 1ps
module lattice_neighbor_index_top
  import lni_pkg::*;
#(
  parameter int SIDE_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  lni_in_if.sink               in_ch,
  lni_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [DIR_W-1:0]     cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int SB    = SIDE_BITS;
  localparam int SW    = SIDE_BITS + 1;
  localparam int DIV_N = NDIM * DIV_ST;
  localparam int STP   = DIV_N;          // step stage
  localparam int NST   = DIV_N + NDIM;   // step + three fold stages
  localparam int LAST  = NST - 1;

  // configuration
  logic [CFG_W-1:0] side_r [NDIM];
  logic [SW-1:0]    side   [NDIM];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NDIM; i++) side_r[i] <= CFG_W'(8);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_SIDE_DIM0: side_r[0] <= cfg_wdata;
        REG_SIDE_DIM1: side_r[1] <= cfg_wdata;
        REG_SIDE_DIM2: side_r[2] <= cfg_wdata;
        REG_SIDE_DIM3: side_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < NDIM; i++) begin
      if (side_r[i] == '0)
        side[i] = SW'(1);
      else if (32'(side_r[i]) > (32'(1) << SB))
        side[i] = SW'(32'(1) << SB);
      else
        side[i] = SW'(side_r[i]);
    end
  end

  // BPS restoring-division steps on the running quotient/remainder
  function automatic logic [IDX_W+SB-1:0] div_step(input logic [SB-1:0] rem_i,
                                                     input logic [IDX_W-1:0] q_i,
                                                     input logic [SW-1:0] dv);
    logic [SW-1:0]    t;
    logic [SB-1:0]    r;
    logic [IDX_W-1:0] q;
    r = rem_i;
    q = q_i;
    for (int k = 0; k < BPS; k++) begin
      t = {r, q[IDX_W-1]};
      q = {q[IDX_W-2:0], 1'b0};
      if (t >= dv) begin
        t    = t - dv;
        q[0] = 1'b1;
      end
      r = t[SB-1:0];
    end
    return {r, q};
  endfunction

  // pipeline registers
  logic                       vld_r [NST];
  logic [DIR_W-1:0]           dir_r [NST];
  logic                       knd_r [NST];
  logic [NDIM-1:0][SB-1:0]    crd_r [NST];
  logic [IDX_W-1:0]           q_r   [DIV_N];
  logic [SB-1:0]              rem_r [DIV_N];
  logic                       err_r [STP:LAST];
  logic [IDX_W-1:0]           acc_r [STP+1:LAST];

  logic adv;
  assign adv         = !vld_r[LAST] || out_ch.ready;
  assign in_ch.ready = adv;

  genvar s;
  generate
    for (s = 0; s < DIV_N; s++) begin : g_div
      localparam int D = NDIM - 1 - s / DIV_ST;
      logic [IDX_W-1:0]        q_in;
      logic [SB-1:0]           rem_in;
      logic                    v_in;
      logic [DIR_W-1:0]        dir_in;
      logic                    knd_in;
      logic [NDIM-1:0][SB-1:0] crd_in;
      logic [NDIM-1:0][SB-1:0] crd_nxt;
      logic [IDX_W+SB-1:0]     res;

      if (s == 0) begin : g_first
        assign q_in   = in_ch.site_index;
        assign v_in   = in_ch.valid;
        assign dir_in = in_ch.direction;
        assign knd_in = in_ch.kind;
        assign crd_in = '0;
      end else begin : g_next
        assign q_in   = q_r[s-1];
        assign v_in   = vld_r[s-1];
        assign dir_in = dir_r[s-1];
        assign knd_in = knd_r[s-1];
        assign crd_in = crd_r[s-1];
      end
      if (s % DIV_ST == 0) begin : g_rz
        assign rem_in = '0;
      end else begin : g_rc
        assign rem_in = rem_r[s-1];
      end

      assign res = div_step(rem_in, q_in, side[D]);

      // last stage of a dimension: remainder is that coordinate
      always_comb begin
        crd_nxt = crd_in;
        if (s % DIV_ST == DIV_ST - 1) crd_nxt[D] = res[IDX_W+SB-1:IDX_W];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) vld_r[s] <= 1'b0;
        else if (adv) vld_r[s] <= v_in;
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          q_r[s]   <= res[IDX_W-1:0];
          rem_r[s] <= res[IDX_W+SB-1:IDX_W];
          dir_r[s] <= dir_in;
          knd_r[s] <= knd_in;
          crd_r[s] <= crd_nxt;
        end
      end
    end
  endgenerate

  // step stage: quotient left after all dimensions means out of volume
  logic [SB-1:0]           c_cur;
  logic [SW-1:0]           s_cur;
  logic [SW-1:0]           c_new;
  logic [NDIM-1:0][SB-1:0] crd_stp_nxt;
  always_comb begin
    c_cur = crd_r[STP-1][dir_r[STP-1]];
    s_cur = side[dir_r[STP-1]];
    if (knd_r[STP-1])
      c_new = (c_cur == '0) ? s_cur - SW'(1) : SW'(c_cur) - SW'(1);
    else
      c_new = (SW'(c_cur) + SW'(1) == s_cur) ? '0 : SW'(c_cur) + SW'(1);
    crd_stp_nxt = crd_r[STP-1];
    crd_stp_nxt[dir_r[STP-1]] = c_new[SB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[STP] <= 1'b0;
    else if (adv) vld_r[STP] <= vld_r[STP-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dir_r[STP] <= dir_r[STP-1];
      knd_r[STP] <= knd_r[STP-1];
      err_r[STP] <= (q_r[STP-1] != '0);
      crd_r[STP] <= crd_stp_nxt;
    end
  end

  // fold stages: acc = acc*side[j] + crd[j]; the last gives zero on error
  generate
    for (s = STP + 1; s < NST; s++) begin : g_fold
      localparam int J = s - STP;
      logic [IDX_W-1:0]    acc_in;
      logic [IDX_W+SW-1:0] prod;
      if (J == 1) begin : g_a0
        assign acc_in = IDX_W'(crd_r[s-1][0]);
      end else begin : g_an
        assign acc_in = acc_r[s-1];
      end
      assign prod = acc_in * side[J];

      always_ff @(posedge clk) begin
        if (!rst_n) vld_r[s] <= 1'b0;
        else if (adv) vld_r[s] <= vld_r[s-1];
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          dir_r[s] <= dir_r[s-1];
          knd_r[s] <= knd_r[s-1];
          crd_r[s] <= crd_r[s-1];
          err_r[s] <= err_r[s-1];
          if (s == LAST && err_r[s-1])
            acc_r[s] <= '0;
          else
            acc_r[s] <= prod[IDX_W-1:0] + IDX_W'(crd_r[s-1][J]);
        end
      end
    end
  endgenerate

  assign out_ch.valid          = vld_r[LAST];
  assign out_ch.neighbor_index = acc_r[LAST];
  assign out_ch.index_error    = err_r[LAST];

  // unused by the fold, kept only for uniform stage records
  logic unused_ok;
  assign unused_ok = ^{dir_r[LAST], knd_r[LAST], crd_r[LAST]};

  // assertions
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.index_error |-> out_ch.neighbor_index == '0)
    else $error("error result with nonzero index");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("accepted item not captured");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[STP] && adv |=> vld_r[STP+1])
    else $error("item dropped in fold pipeline");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(acc_r[LAST]) && !in_ch.ready == !adv)
    else $error("output changed while stalled");

endmodule
